/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/scls_pkg.sv */
// ----------------------------------------------------------------------------
// scls_pkg
// Types, constants and lookup functions shared by the sine/cosine fit block.
// ----------------------------------------------------------------------------
package scls_pkg;

    localparam int BASIS_COUNT      = 3;
    localparam int MAX_SAMPLES_DEF  = 65536;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SUM_W  = 48;
    localparam int NSUM   = 9;
    localparam int ANG_W  = 34;
    localparam int CV_W   = 18;
    localparam int V_W    = 20;
    localparam int P_W    = 2 * V_W;
    localparam int ACC_W  = 64;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 4;
    localparam int SH_W   = 6;
    localparam int COEF_W = 32;
    localparam int DIV_STEPS = 32;

    localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629714;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

    typedef logic [3:0] op_t;
    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_WRAP    = 4'd2;
    localparam op_t OP_ROT     = 4'd3;
    localparam op_t OP_SC      = 4'd4;
    localparam op_t OP_ACC     = 4'd5;
    localparam op_t OP_MAX     = 4'd6;
    localparam op_t OP_NORM    = 4'd7;
    localparam op_t OP_SCALE   = 4'd8;
    localparam op_t OP_DET     = 4'd9;
    localparam op_t OP_DSTORE  = 4'd10;
    localparam op_t OP_DIVINIT = 4'd11;
    localparam op_t OP_DIVSTEP = 4'd12;
    localparam op_t OP_DIVFIN  = 4'd13;
    localparam op_t OP_OUT     = 4'd14;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic             first;
        logic             neg;
        logic [IDX_W-1:0] vsel;
        logic [1:0]       csel;
    } cmd_t;

    typedef struct packed {
        logic z_in_range;
        logic sums_full;
        logic norm_done;
        logic acc_zero;
        logic out_free;
    } stat_t;

    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 34'sd210828714;
            5'd1:    r = 34'sd124459457;
            5'd2:    r = 34'sd65760959;
            5'd3:    r = 34'sd33381290;
            5'd4:    r = 34'sd16755422;
            5'd5:    r = 34'sd8385879;
            5'd6:    r = 34'sd4193963;
            5'd7:    r = 34'sd2097109;
            5'd8:    r = 34'sd1048571;
            5'd9:    r = 34'sd524287;
            default: r = 34'sd268435456 >>> i;
        endcase
        return r;
    endfunction

    // column used by row f in term t of the six-term determinant expansion
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] f);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        case (f)
            2'd0:    return p[1:0];
            2'd1:    return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    function automatic logic perm_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

    // storage slot of element (r, c) of determinant j; j > 0 swaps column j-1 for b
    function automatic logic [IDX_W-1:0] det_elem(input logic [1:0] j, input logic [1:0] r,
                                                  input logic [1:0] c);
        logic [1:0] lo;
        logic [1:0] hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        if ((j != 2'd0) && (c == j - 2'd1))
            return IDX_W'(6) + IDX_W'(r);
        case ({lo, hi})
            4'b0000: return IDX_W'(0);
            4'b0001: return IDX_W'(1);
            4'b0010: return IDX_W'(2);
            4'b0101: return IDX_W'(3);
            4'b0110: return IDX_W'(4);
            default: return IDX_W'(5);
        endcase
    endfunction

endpackage

/* sv/scls_ctrl.sv */
// ----------------------------------------------------------------------------
// scls_ctrl
// Sequencer: CORDIC, accumulation, scaling, determinant and division steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scls_ctrl
    import scls_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  logic  s_tlast,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WRAP    = 4'd1;
    localparam logic [3:0] S_ROT     = 4'd2;
    localparam logic [3:0] S_SC      = 4'd3;
    localparam logic [3:0] S_ACC     = 4'd4;
    localparam logic [3:0] S_MAX     = 4'd5;
    localparam logic [3:0] S_NORM    = 4'd6;
    localparam logic [3:0] S_SCALE   = 4'd7;
    localparam logic [3:0] S_DET     = 4'd8;
    localparam logic [3:0] S_DETEND  = 4'd9;
    localparam logic [3:0] S_DIV     = 4'd10;
    localparam logic [3:0] S_DIVFIN  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] SUM_LAST = CNT_W'(NSUM - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic [1:0]       didx_reg, didx_next;
    logic [2:0]       term_reg, term_next;
    logic [1:0]       phase_reg, phase_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        didx_next  = didx_reg;
        term_next  = term_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg;
        cmd.csel   = didx_reg - 2'd1;
        cmd.first  = (term_reg == 3'd0);
        cmd.neg    = perm_neg(term_reg);
        cmd.vsel   = det_elem(didx_reg, phase_reg, perm_col(term_reg, phase_reg));
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op    = OP_LOAD;
                    last_next = s_tlast;
                    cnt_next  = '0;
                    if (!st.sums_full)
                        state_next = S_WRAP;
                    else if (s_tlast)
                        state_next = S_MAX;
                end
            end
            S_WRAP:
            begin
                cmd.op = OP_WRAP;
                if (st.z_in_range)
                begin
                    state_next = S_ROT;
                    cnt_next   = '0;
                end
            end
            S_ROT:
            begin
                cmd.op = OP_ROT;
                if (cnt_reg == ROT_LAST)
                begin
                    state_next = S_SC;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SC:
            begin
                cmd.op     = OP_SC;
                state_next = S_ACC;
                cnt_next   = '0;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (cnt_reg == SUM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = last_reg ? S_MAX : S_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MAX:
            begin
                cmd.op = OP_MAX;
                if (cnt_reg == SUM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_NORM;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_NORM:
            begin
                if (st.norm_done)
                begin
                    state_next = S_SCALE;
                    cnt_next   = '0;
                end
                else
                    cmd.op = OP_NORM;
            end
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                if (cnt_reg == SUM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DET;
                    didx_next  = 2'd0;
                    term_next  = 3'd0;
                    phase_next = 2'd0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DET:
            begin
                cmd.op  = OP_DET;
                cmd.idx = CNT_W'(phase_reg);
                if (phase_reg == 2'd2)
                begin
                    phase_next = 2'd0;
                    if (term_reg == 3'd5)
                    begin
                        term_next  = 3'd0;
                        state_next = S_DETEND;
                    end
                    else
                        term_next = term_reg + 3'd1;
                end
                else
                    phase_next = phase_reg + 2'd1;
            end
            S_DETEND:
            begin
                cnt_next = '0;
                if (didx_reg == 2'd0)
                begin
                    cmd.op    = OP_DSTORE;
                    didx_next = 2'd1;
                    state_next = st.acc_zero ? S_OUT : S_DET;
                end
                else
                begin
                    cmd.op     = OP_DIVINIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIVSTEP;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIVFIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DIVFIN:
            begin
                cmd.op = OP_DIVFIN;
                if (didx_reg == 2'd3)
                    state_next = S_OUT;
                else
                begin
                    didx_next  = didx_reg + 2'd1;
                    state_next = S_DET;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            didx_reg  <= 2'd0;
            term_reg  <= 3'd0;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            didx_reg  <= didx_next;
            term_reg  <= term_next;
            phase_reg <= phase_next;
        end
    end

    `ASSERT_IMPLY(a_out_free, cmd.op == OP_OUT, st.out_free, "result loaded over pending item")
    `ASSERT_IMPLY(a_div_order, cmd.op == OP_DIVFIN, $past(cmd.op) == OP_DIVSTEP,
                  "division finished without steps")
    `ASSERT_IMPLY(a_rot_range, state_reg == S_ROT, cnt_reg <= ROT_LAST, "rotation overrun")
    `ASSERT_IMPLY(a_det_phase, state_reg == S_DET, phase_reg != 2'd3, "bad product phase")

endmodule

/* sv/scls_dp.sv */
// ----------------------------------------------------------------------------
// scls_dp
// Datapath: CORDIC, normal-equation sums, scaling, determinants and divider.
// ----------------------------------------------------------------------------
module scls_dp
    import scls_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         s_tdata,
    input  cmd_t                cmd,
    output stat_t               st,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [3*COEF_W-1:0] m_tdata,
    output logic                m_tuser
);

    logic signed [ANG_W-1:0]  z_reg, cx_reg, cy_reg;
    logic                     flip_reg;
    logic signed [15:0]       y_reg;
    logic signed [CV_W-1:0]   s_reg, c_reg;
    logic signed [SUM_W-1:0]  sums_reg [NSUM];
    logic [ACC_W-1:0]         mx_reg;
    logic [SH_W-1:0]          sh_reg;
    logic signed [V_W-1:0]    v_reg [NSUM];
    logic signed [V_W-1:0]    op_reg;
    logic signed [P_W-1:0]    p_reg;
    logic signed [ACC_W-1:0]  acc_reg, d_reg;
    logic [ACC_W-1:0]         rem_reg, ud_reg;
    logic [31:0]              nlow_reg, q_reg;
    logic                     ovf_reg, neg_reg;
    logic [COEF_W-1:0]        coef_reg [BASIS_COUNT];
    logic                     m_tvalid_reg;
    logic [3*COEF_W-1:0]      m_tdata_reg;
    logic                     m_tuser_reg;

    logic [IDX_W-1:0]         aidx;
    logic [4:0]               ridx;
    logic signed [ANG_W-1:0]  dx, dy, at, sy, sx;
    logic signed [CV_W-1:0]   ma, mb;
    logic signed [2*CV_W-1:0] mp;
    logic signed [SUM_W-1:0]  term, ssel;
    logic signed [SUM_W:0]    ssum;
    logic signed [SUM_W-1:0]  snew;
    logic signed [ACC_W-1:0]  wide, wshift;
    logic [ACC_W-1:0]         wabs;
    logic signed [V_W-1:0]    vr;
    logic signed [P_W+V_W-1:0] tfull;
    logic signed [ACC_W-1:0]  tprod;
    logic [ACC_W-1:0]         un, ud;
    logic [ACC_W:0]           r2;
    logic [COEF_W:0]          mag;
    logic [COEF_W-1:0]        res;

    assign aidx = cmd.idx[IDX_W-1:0];
    assign ridx = cmd.idx[4:0];
    assign dx   = cy_reg >>> ridx;
    assign dy   = cx_reg >>> ridx;
    assign at   = atan_q28(ridx);
    assign sy   = (flip_reg ? -cy_reg : cy_reg) + 34'sd32768;
    assign sx   = (flip_reg ? -cx_reg : cx_reg) + 34'sd32768;
    assign ssel = sums_reg[aidx];
    assign vr   = v_reg[cmd.vsel];

    always_comb
    begin
        ma = s_reg;
        mb = s_reg;
        case (aidx)
            4'd1:    mb = c_reg;
            4'd3:
            begin
                ma = c_reg;
                mb = c_reg;
            end
            4'd6:    ma = CV_W'(y_reg);
            4'd7:
            begin
                ma = CV_W'(y_reg);
                mb = c_reg;
            end
            default: ;
        endcase
        mp = ma * mb;
        case (aidx)
            4'd2:    term = SUM_W'(s_reg);
            4'd4:    term = SUM_W'(c_reg);
            4'd5:    term = SUM_W'(1);
            4'd8:    term = SUM_W'(y_reg);
            default: term = SUM_W'(mp);
        endcase
        ssum = {ssel[SUM_W-1], ssel} + {term[SUM_W-1], term};
        if (ssum[SUM_W] != ssum[SUM_W-1])
            snew = ssum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            snew = ssum[SUM_W-1:0];
    end

    always_comb
    begin
        wide = ACC_W'(ssel);
        case (aidx)
            4'd2, 4'd4: wide = ACC_W'(ssel) <<< 14;
            4'd5:       wide = ACC_W'(ssel) <<< 28;
            4'd6, 4'd7: wide = ACC_W'(ssel) <<< 6;
            4'd8:       wide = ACC_W'(ssel) <<< 20;
            default:    ;
        endcase
        wabs   = wide[ACC_W-1] ? ACC_W'(-wide) : ACC_W'(wide);
        wshift = wide >>> sh_reg;
        tfull  = p_reg * vr;
        tprod  = ACC_W'(tfull);
        un     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        ud     = d_reg[ACC_W-1] ? ACC_W'(-d_reg) : ACC_W'(d_reg);
        r2     = {rem_reg, nlow_reg[31]};
        mag    = {2'b00, q_reg[31:1]} + {{COEF_W{1'b0}}, q_reg[0]};
        if (ovf_reg)
            res = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (!neg_reg)
            res = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[COEF_W-1:0];
        else
            res = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : COEF_W'(-mag);
    end

    assign st.z_in_range = !(z_reg > PI_Q28) && !(z_reg < -PI_Q28);
    assign st.sums_full  = sums_reg[5] >= $signed(SUM_W'(MAX_SAMPLES));
    assign st.norm_done  = (mx_reg[ACC_W-1:19] == '0) || (sh_reg == SH_W'(62));
    assign st.acc_zero   = (acc_reg == '0);
    assign st.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < NSUM; k++)
                sums_reg[k] <= '0;
        end
        else
        begin
            if (cmd.op == OP_OUT)
            begin
                m_tvalid_reg <= 1'b1;
                for (int k = 0; k < NSUM; k++)
                    sums_reg[k] <= '0;
            end
            else
            begin
                if (m_tready)
                    m_tvalid_reg <= 1'b0;
                if (cmd.op == OP_ACC)
                    sums_reg[aidx] <= snew;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                z_reg    <= {{2{s_tdata[15]}}, s_tdata[15:0], 16'h0000};
                y_reg    <= s_tdata[31:16];
                flip_reg <= 1'b0;
            end
            OP_WRAP:
            begin
                if (z_reg > PI_Q28)
                    z_reg <= z_reg - TWO_PI_Q28;
                else if (z_reg < -PI_Q28)
                    z_reg <= z_reg + TWO_PI_Q28;
                else
                begin
                    cx_reg <= GAIN_Q30;
                    cy_reg <= '0;
                    if (z_reg > HALF_PI_Q28)
                    begin
                        z_reg    <= z_reg - PI_Q28;
                        flip_reg <= 1'b1;
                    end
                    else if (z_reg < -HALF_PI_Q28)
                    begin
                        z_reg    <= z_reg + PI_Q28;
                        flip_reg <= 1'b1;
                    end
                end
            end
            OP_ROT:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + at;
                end
            end
            OP_SC:
            begin
                s_reg <= sy[ANG_W-1:16];
                c_reg <= sx[ANG_W-1:16];
            end
            OP_MAX:
            begin
                if ((aidx == '0) || (wabs > mx_reg))
                    mx_reg <= wabs;
                if (aidx == '0)
                    sh_reg <= '0;
            end
            OP_NORM:
            begin
                mx_reg <= mx_reg >> 1;
                sh_reg <= sh_reg + 1'b1;
            end
            OP_SCALE:
            begin
                v_reg[aidx] <= wshift[V_W-1:0];
            end
            OP_DET:
            begin
                if (cmd.idx[1:0] == 2'd0)
                    op_reg <= vr;
                else if (cmd.idx[1:0] == 2'd1)
                    p_reg <= op_reg * vr;
                else
                    acc_reg <= (cmd.first ? '0 : acc_reg) + (cmd.neg ? -tprod : tprod);
            end
            OP_DSTORE:
            begin
                d_reg <= acc_reg;
            end
            OP_DIVINIT:
            begin
                ud_reg   <= ud;
                neg_reg  <= acc_reg[ACC_W-1] ^ d_reg[ACC_W-1];
                ovf_reg  <= {15'h0000, un} >= {ud, 15'h0000};
                rem_reg  <= un >> 15;
                nlow_reg <= {un[14:0], 17'h00000};
                q_reg    <= '0;
            end
            OP_DIVSTEP:
            begin
                nlow_reg <= nlow_reg << 1;
                if (r2 >= {1'b0, ud_reg})
                begin
                    rem_reg <= ACC_W'(r2 - {1'b0, ud_reg});
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2[ACC_W-1:0];
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
            end
            OP_DIVFIN:
            begin
                coef_reg[cmd.csel] <= res;
            end
            OP_OUT:
            begin
                m_tuser_reg <= (d_reg == '0);
                m_tdata_reg <= (d_reg == '0) ? '0 :
                               {coef_reg[2], coef_reg[1], coef_reg[0]};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* sv/sine_cosine_least_squares_fit.sv */
// ----------------------------------------------------------------------------
// sine_cosine_least_squares_fit
// Fits y = c0*sin(x) + c1*cos(x) + c2 over a set of samples by least squares.
//
//  channel  direction  payload (low bit up)
//  s_*      in         tdata: x_angle[15:0], y_value[31:16]; tlast: last_sample
//  m_*      out        tdata: coef_sine, coef_cosine, coef_constant; tuser: singular
//
// A sample passes through load, one or two angle wrap steps, CORDIC_STEPS CORDIC
// iterations at one a cycle, rounding, then nine sum updates through one 18x18
// multiplier; once MAX_SAMPLES samples are summed, a sample is only loaded.
// A final sample adds the solve: a maximum search and scaling over the nine
// sums with normalize shifts between them, the determinant, then for each of
// three numerators its determinant and restoring division, and the result load.
// A singular set skips the numerators and divisions.
// The result waits in an output register; the next sample is taken meanwhile.
// A result still waiting there holds the next solve before its result load.
// Reset clears the sums and the result channel.
// ----------------------------------------------------------------------------
module sine_cosine_least_squares_fit
    import scls_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // x_angle, y_value
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [3*COEF_W-1:0] m_tdata,   // coef_sine, coef_cosine, coef_constant
    output logic                m_tuser    // singular
);

    cmd_t  cmd;
    stat_t st;

    scls_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    scls_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* verif/sine_cosine_least_squares_fit_chk.sv */
// ----------------------------------------------------------------------------
// sine_cosine_least_squares_fit_chk
// Watches both streams of the fit block and predicts every coefficient set
// from the accepted samples. It uses CORDIC sine and cosine, saturating
// normal sums and a Cramer solve. Each result is compared field by field,
// and a failure count goes back to the top.
// ----------------------------------------------------------------------------
module sine_cosine_least_squares_fit_chk
    import scls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [31:0]         s_tdata,   // x_angle, y_value
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [3*COEF_W-1:0] m_tdata,   // coef_sine, coef_cosine, coef_constant
    input  logic                m_tuser,   // singular
    output int                  errors,
    output int                  pending
);

    localparam longint SUM_HI    = 64'sh7FFFFFFFFFFF;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam longint PI_VAL    = 843314857;
    localparam longint HALF_PI   = 421657428;
    localparam longint GAIN_VAL  = 652032874;
    localparam int     MAX_COUNT = 65536;
    localparam int     STEPS     = 16;

    typedef longint mat_t[9];

    typedef struct packed {
        logic [31:0] coef_sine;
        logic [31:0] coef_cosine;
        logic [31:0] coef_constant;
        logic        singular;
    } fit_t;

    longint fit_sums[9];
    longint arctan_tab[STEPS];
    fit_t   fit_queue[$];

    function automatic longint arctan_series(int i);
        longint unsigned acc;
        longint unsigned term;
        int e;
        acc = 0;
        if (i == 0)
            return 210828714;
        for (int k = 0; k < 64; k++)
        begin
            e = i * (2 * k + 1);
            if (e > 60)
                break;
            term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
        longint z;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        bit flip;
        z = longint'(ang) * 65536;
        cx = GAIN_VAL;
        cy = 0;
        flip = 0;
        while (z > PI_VAL)
            z = z - 2 * PI_VAL;
        while (z < -PI_VAL)
            z = z + 2 * PI_VAL;
        if (z > HALF_PI)
        begin
            z = z - PI_VAL;
            flip = 1;
        end
        else if (z < -HALF_PI)
        begin
            z = z + PI_VAL;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - arctan_tab[i];
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + arctan_tab[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        s = (cy + 32768) >>> 16;
        c = (cx + 32768) >>> 16;
    endtask

    task automatic add_sat(input int idx, input longint v);
        longint r;
        r = fit_sums[idx] + v;
        if (r > SUM_HI)
            r = SUM_HI;
        if (r < SUM_LO)
            r = SUM_LO;
        fit_sums[idx] = r;
    endtask

    function automatic longint det3(mat_t m);
        return m[0] * (m[4] * m[8] - m[5] * m[7])
             - m[1] * (m[3] * m[8] - m[5] * m[6])
             + m[2] * (m[3] * m[7] - m[4] * m[6]);
    endfunction

    function automatic logic [31:0] quotient_q16(longint n, longint d);
        bit neg;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned r;
        longint unsigned f;
        longint unsigned mag;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        r = un % ud;
        f = 0;
        if (q >= (64'd1 << 15))
            return neg ? 32'h80000000 : 32'h7FFFFFFF;
        for (int k = 0; k < 17; k++)
        begin
            r = r << 1;
            f = f << 1;
            if (r >= ud)
            begin
                r = r - ud;
                f = f | 1;
            end
        end
        mag = (q << 16) + (f >> 1) + (f & 1);
        if (!neg)
            return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        if (mag > 64'h80000000)
            mag = 64'h80000000;
        return 32'(-mag);
    endfunction

    function automatic fit_t solve_fit();
        mat_t a;
        mat_t t;
        longint b[3];
        longint mx;
        longint v;
        longint d;
        logic [31:0] coef[3];
        int sh;
        fit_t res;
        a[0] = fit_sums[0];
        a[1] = fit_sums[1];
        a[2] = fit_sums[2] * 16384;
        a[4] = fit_sums[3];
        a[5] = fit_sums[4] * 16384;
        a[8] = fit_sums[5] * 268435456;
        a[3] = a[1];
        a[6] = a[2];
        a[7] = a[5];
        b[0] = fit_sums[6] * 64;
        b[1] = fit_sums[7] * 64;
        b[2] = fit_sums[8] * 1048576;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            v = (b[i] < 0) ? -b[i] : b[i];
            if (v > mx)
                mx = v;
            for (int j = 0; j < 3; j++)
            begin
                v = (a[3 * i + j] < 0) ? -a[3 * i + j] : a[3 * i + j];
                if (v > mx)
                    mx = v;
            end
        end
        sh = 0;
        while (sh < 62 && (mx >>> sh) >= (64'sd1 << 19))
            sh++;
        for (int i = 0; i < 3; i++)
        begin
            b[i] = b[i] >>> sh;
            for (int j = 0; j < 3; j++)
                a[3 * i + j] = a[3 * i + j] >>> sh;
        end
        d = det3(a);
        res = '0;
        if (d == 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    t[3 * i + j] = (j == k) ? b[i] : a[3 * i + j];
            coef[k] = quotient_q16(det3(t), d);
        end
        res.coef_sine     = coef[0];
        res.coef_cosine   = coef[1];
        res.coef_constant = coef[2];
        return res;
    endfunction

    task automatic take_sample(input logic signed [15:0] ang, input logic signed [15:0] y,
                               input logic last);
        longint s;
        longint c;
        longint yv;
        yv = longint'(y);
        if (fit_sums[5] < MAX_COUNT)
        begin
            sin_cos(ang, s, c);
            add_sat(0, s * s);
            add_sat(1, s * c);
            add_sat(2, s);
            add_sat(3, c * c);
            add_sat(4, c);
            add_sat(5, 1);
            add_sat(6, yv * s);
            add_sat(7, yv * c);
            add_sat(8, yv);
        end
        if (last)
        begin
            fit_queue.push_back(solve_fit());
            for (int i = 0; i < 9; i++)
                fit_sums[i] = 0;
        end
    endtask

    initial
    begin
        errors = 0;
        for (int i = 0; i < 9; i++)
            fit_sums[i] = 0;
        for (int i = 0; i < STEPS; i++)
            arctan_tab[i] = arctan_series(i);
    end

    assign pending = fit_queue.size();

    always @(posedge clk)
    begin
        fit_t want;
        if (rst_n && s_tvalid && s_tready)
            take_sample(s_tdata[15:0], s_tdata[31:16], s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (fit_queue.size() == 0)
            begin
                $error("unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = fit_queue.pop_front();
                if (m_tdata[31:0] !== want.coef_sine)
                begin
                    $error("coef_sine: expected %h actual %h", want.coef_sine, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.coef_cosine)
                begin
                    $error("coef_cosine: expected %h actual %h", want.coef_cosine,
                           m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== want.coef_constant)
                begin
                    $error("coef_constant: expected %h actual %h", want.coef_constant,
                           m_tdata[95:64]);
                    errors++;
                end
                if (m_tuser !== want.singular)
                begin
                    $error("singular: expected %b actual %b", want.singular, m_tuser);
                    errors++;
                end
            end
        end
    end

endmodule

/* verif/sine_cosine_least_squares_fit_tb.sv */
// ----------------------------------------------------------------------------
// sine_cosine_least_squares_fit_tb
// Drives sample sets into the fit block: first directed sets, then random sets
// of random size, in bursts, while the result side stalls on its own pattern.
// The checker predicts and compares. The verdict comes from its failure count.
// ----------------------------------------------------------------------------
module sine_cosine_least_squares_fit_tb;
    import scls_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // x_angle, y_value
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [3*COEF_W-1:0] m_tdata;   // coef_sine, coef_cosine, coef_constant
    logic                m_tuser;   // singular
    int                  errors;
    int                  pending;
    int                  burst_left;
    int                  ready_pct;
    longint              cycles;

    sine_cosine_least_squares_fit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sine_cosine_least_squares_fit_chk chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0)
            ready_pct <= ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 90);
        m_tready <= ($urandom_range(0, 99) < ready_pct);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] ang, input logic [15:0] y, input logic last);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, ang};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random_set(input int n);
        logic [15:0] ang;
        logic [15:0] y;
        int mode;
        mode = $urandom_range(0, 3);
        ang = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (mode != 0 || i == 0)
                ang = 16'($urandom);
            if (mode == 1)
                y = 16'($urandom_range(0, 2047) - 1024);
            else
                y = 16'($urandom);
            send_sample(ang, y, i == n - 1);
        end
    endtask

    initial
    begin
        int sent;
        int n;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cycles     = 0;
        ready_pct  = 100;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sh0000, 16'sh7FFF, 1'b1);
        send_sample(16'sh1000, 16'sh0100, 1'b0);
        send_sample(16'sh1000, 16'sh0100, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 16'sh0000, 1'b0);
        send_sample(16'shFFFF, 16'shFFFF, 1'b1);
        send_sample(16'sh1922, 16'sh7FFF, 1'b0);
        send_sample(16'shE6DE, 16'sh8000, 1'b0);
        send_sample(16'sh3244, 16'sh0001, 1'b0);
        send_sample(16'shCDBC, 16'sh5555, 1'b1);
        send_sample(16'sh0800, 16'sh0000, 1'b0);
        send_sample(16'sh2000, 16'sh0000, 1'b0);
        send_sample(16'sh4000, 16'sh0000, 1'b0);
        send_sample(16'shAAAA, 16'sh0000, 1'b1);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat ($urandom_range(300, 400)) @(posedge clk);

        sent = 0;
        while (sent < 850)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            send_random_set(n);
            sent += n;
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
